// ===== hw/rtl/sqad_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types, a saturation helper, a table-time divider and the 2^-x table of the attention decoder.
package sqad_pkg;

    localparam int HEAD_DIM   = 256;
    localparam int LANES      = 4;
    localparam int CHUNKS     = HEAD_DIM / LANES;
    localparam int MAX_TOKENS = 8192;
    localparam int EXP_DEPTH  = 256;

    localparam int ELEM_W   = 16;
    localparam int CHUNK_W  = 6;
    localparam int TOKIDX_W = 13;
    localparam int COUNT_W  = 14;
    localparam int SCORE_W  = 32;
    localparam int ACC_W    = 48;
    localparam int EXP_W    = 17;
    localparam int EIDX_W   = $clog2(EXP_DEPTH);

    localparam longint unsigned LN2_Q30   = 64'd744261118;
    localparam longint unsigned LOG2E_Q30 = 64'd1549082005;

    localparam logic [1:0] KIND_QUERY = 2'd0;
    localparam logic [1:0] KIND_KEY   = 2'd1;
    localparam logic [1:0] KIND_VALUE = 2'd2;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_KEYS   = 2'd1;
    localparam logic [1:0] PH_VALUES = 2'd2;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic [EXP_W-1:0] exp_table_t [EXP_DEPTH];

    // Divider handshake between the controller and the reciprocal unit.
    typedef struct packed {
        logic        start;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] x);
        logic signed [ACC_W:0] hi;
        logic signed [ACC_W:0] lo;
        hi = {2'b00, {(ACC_W-1){1'b1}}};
        lo = {2'b11, {(ACC_W-1){1'b0}}};
        if (x > hi)
            return hi[ACC_W-1:0];
        else if (x < lo)
            return lo[ACC_W-1:0];
        else
            return x[ACC_W-1:0];
    endfunction

    // Shift-and-subtract division, used only while building constant tables.
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Entry i is round(2^16 * 2^(-i/EXP_DEPTH)), from a Q.30 Taylor series.
    function automatic exp_table_t build_exp_table();
        exp_table_t      tbl;
        longint unsigned iu;
        longint unsigned u;
        longint unsigned z;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned n;
        for (int i = 0; i < EXP_DEPTH; i++)
        begin
            iu   = longint'(i);
            u    = (iu << 30) >> EIDX_W;
            z    = (u * LN2_Q30 + (64'd1 << 29)) >> 30;
            term = 64'd1 << 30;
            pos  = 64'd1 << 30;
            neg  = 64'd0;
            for (n = 1; n <= 12; n++)
            begin
                term = udiv64((term * z) >> 30, n);
                if (n[0])
                    neg = neg + term;
                else
                    pos = pos + term;
            end
            tbl[i] = EXP_W'(((pos - neg) + (64'd1 << 13)) >> 14);
        end
        return tbl;
    endfunction

    localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

// ===== hw/rtl/single_query_attention_decoder_unit.sv =====
`timescale 1ns / 1ps
// Query items are stored; key chunks multiply and accumulate, the last one scaling the dot
// product and writing the score. Value chunks update the accumulator row; the first one also
// walks the score store for the softmax sum, then runs the reciprocal divider if nonzero.
// Row emission: 64 results, one at a time, each held through any output stall.
// Throughput: one item at a time through the control sequencer; in_stall is high while busy.
// Reset: asynchronous, active low; query and score stores hold undefined data until written.
module single_query_attention_decoder_unit
    import sqad_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               kind,
    input  logic [TOKIDX_W-1:0]      token_index,
    input  logic [CHUNK_W-1:0]       chunk_index,
    input  logic [COUNT_W-1:0]       token_count,
    input  logic signed [ELEM_W-1:0] value_0,
    input  logic signed [ELEM_W-1:0] value_1,
    input  logic signed [ELEM_W-1:0] value_2,
    input  logic signed [ELEM_W-1:0] value_3,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [CHUNK_W-1:0]       out_chunk,
    output logic signed [ELEM_W-1:0] out_0,
    output logic signed [ELEM_W-1:0] out_1,
    output logic signed [ELEM_W-1:0] out_2,
    output logic signed [ELEM_W-1:0] out_3,
    output logic                     out_last,
    input  logic                     cfg_wr_en,
    input  logic [15:0]              cfg_wr_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE,
        S_K_MUL, S_K_ACC, S_K_SCALE, S_K_SCORE,
        S_W_RUN, S_W_DIV,
        S_V_RD, S_V_EXP, S_V_MAC, S_V_WR,
        S_E_RD, S_E_LOAD, S_E_WAIT
    } state_t;

    localparam int ROW_W = LANES * ELEM_W;
    localparam int ACCROW_W = LANES * ACC_W;
    localparam int SADDR_W = $clog2(MAX_TOKENS);
    localparam logic [CHUNK_W-1:0] LAST_CHUNK = CHUNK_W'(CHUNKS - 1);

    // Control state
    state_t                    state_reg;
    logic [1:0]                phase_reg;
    logic [COUNT_W-1:0]        tokens_reg;
    logic [15:0]               scale_reg;
    logic signed [ACC_W-1:0]   dot_reg;
    logic signed [SCORE_W-1:0] max_reg;
    logic [31:0]               sum_reg;
    logic [31:0]               recip_reg;
    logic [CHUNKS-1:0]         acc_valid_reg;
    logic [COUNT_W-1:0]        walk_addr_reg;
    logic [COUNT_W-1:0]        rcv_cnt_reg;
    logic [CHUNK_W-1:0]        emit_cnt_reg;
    logic                      out_valid_reg;
    logic                      sc_rd_valid_reg;
    logic                      div_start_reg;

    // Latched transaction and datapath registers
    logic [1:0]                  kind_reg;
    logic [TOKIDX_W-1:0]         tok_reg;
    logic [CHUNK_W-1:0]          chunk_reg;
    logic [COUNT_W-1:0]          count_reg;
    elem_t                       val_reg [LANES];
    logic signed [31:0]          kprod_reg [LANES];
    logic signed [ACC_W+16:0]    sprod_reg;
    logic [17:0]                 p_reg;
    logic signed [ELEM_W+18:0]   vprod_reg [LANES];
    elem_t                       out_lane_reg [LANES];
    logic [CHUNK_W-1:0]          out_chunk_reg;
    logic                        out_last_reg;

    // Memory ports
    logic                q_we, q_re;
    logic [ROW_W-1:0]    q_wdata, q_rdata;
    logic                s_we, s_re;
    logic [SADDR_W-1:0]  s_raddr;
    logic [SCORE_W-1:0]  s_wdata, s_rdata;
    logic                a_we, a_re;
    logic [CHUNK_W-1:0]  a_raddr;
    logic [ACCROW_W-1:0] a_wdata, a_rdata;

    // Unit connections
    logic             exp_valid;
    logic [EXP_W-1:0] exp_e;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    // Combinational datapath
    logic                      tok_ok;
    logic                      tok_last;
    logic [COUNT_W-1:0]        count_clamped;
    elem_t                     q_lane [LANES];
    logic signed [ACC_W-1:0]   acc_old [LANES];
    logic signed [ACC_W-1:0]   acc_new [LANES];
    logic signed [33:0]        ksum;
    logic signed [ACC_W-1:0]   dot_new;
    logic signed [ACC_W+17:0]  srnd;
    logic signed [SCORE_W-1:0] score_new;
    logic [49:0]               pprod;
    logic [32:0]               sum_add;
    logic signed [ACC_W:0]     ornd [LANES];
    elem_t                     out_sat [LANES];

    always_comb
    begin
        tok_ok   = {1'b0, tok_reg} < tokens_reg;
        tok_last = {1'b0, tok_reg} == tokens_reg - COUNT_W'(1);

        // A zero count means one token; larger counts cap at the store depth.
        if (count_reg == '0)
            count_clamped = COUNT_W'(1);
        else if (count_reg > COUNT_W'(MAX_TOKENS))
            count_clamped = COUNT_W'(MAX_TOKENS);
        else
            count_clamped = count_reg;

        ksum = '0;
        for (int i = 0; i < LANES; i++)
        begin
            q_lane[i] = q_rdata[i*ELEM_W +: ELEM_W];
            ksum      = ksum + 34'(kprod_reg[i]);
        end
        dot_new = sat_acc((ACC_W+1)'(dot_reg) + (ACC_W+1)'(ksum));

        // Score: round half up, arithmetic shift, saturate to 32 bits.
        srnd = ((ACC_W+18)'(sprod_reg) + (ACC_W+18)'(64'sd4194304)) >>> 23;
        if (srnd > (ACC_W+18)'(64'sh7FFF_FFFF))
            score_new = {1'b0, {(SCORE_W-1){1'b1}}};
        else if (srnd < -(ACC_W+18)'(64'sh8000_0000))
            score_new = {1'b1, {(SCORE_W-1){1'b0}}};
        else
            score_new = srnd[SCORE_W-1:0];

        pprod   = 50'(exp_e) * 50'(recip_reg) + (50'd1 << 31);
        sum_add = {1'b0, sum_reg} + 33'(exp_e);

        // Rows not written since the last restart read as zero.
        for (int i = 0; i < LANES; i++)
        begin
            acc_old[i] = acc_valid_reg[a_raddr] ? a_rdata[i*ACC_W +: ACC_W] : '0;
            acc_new[i] = sat_acc((ACC_W+1)'(acc_old[i]) + (ACC_W+1)'(vprod_reg[i]));
            ornd[i]    = ((ACC_W+1)'(acc_old[i]) + (ACC_W+1)'(32768)) >>> 16;
            if (ornd[i] > (ACC_W+1)'(32767))
                out_sat[i] = 16'sh7FFF;
            else if (ornd[i] < -(ACC_W+1)'(32768))
                out_sat[i] = 16'sh8000;
            else
                out_sat[i] = ornd[i][ELEM_W-1:0];
        end
    end

    // Memory and unit control
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            q_wdata[i*ELEM_W +: ELEM_W] = val_reg[i];
            a_wdata[i*ACC_W +: ACC_W]   = acc_new[i];
        end
        q_we = (state_reg == S_DECODE) && (kind_reg == KIND_QUERY);
        q_re = (state_reg == S_DECODE) && (kind_reg == KIND_KEY) && tok_ok
               && (phase_reg == PH_KEYS);

        s_we    = (state_reg == S_K_SCORE);
        s_wdata = score_new;
        s_re    = ((state_reg == S_W_RUN) && (walk_addr_reg < tokens_reg))
                  || (state_reg == S_V_RD);
        s_raddr = (state_reg == S_W_RUN) ? walk_addr_reg[SADDR_W-1:0] : tok_reg;

        a_we    = (state_reg == S_V_WR);
        a_re    = (state_reg == S_V_RD) || (state_reg == S_E_RD);
        a_raddr = (state_reg == S_E_RD || state_reg == S_E_LOAD || state_reg == S_E_WAIT)
                  ? emit_cnt_reg : chunk_reg;

        div_req.start   = div_start_reg;
        div_req.divisor = sum_reg;
    end

    sqad_ram #(.WIDTH(ROW_W), .DEPTH(CHUNKS)) u_query_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (chunk_reg),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (chunk_reg),
        .rdata (q_rdata)
    );

    sqad_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_TOKENS)) u_score_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (tok_reg),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    sqad_ram #(.WIDTH(ACCROW_W), .DEPTH(CHUNKS)) u_acc_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (chunk_reg),
        .wdata (a_wdata),
        .re    (a_re),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    sqad_exp u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sc_rd_valid_reg),
        .score     (s_rdata),
        .run_max   (max_reg),
        .out_valid (exp_valid),
        .e_out     (exp_e)
    );

    sqad_recip u_recip (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequencer: state, row state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_IDLE;
            tokens_reg      <= '0;
            scale_reg       <= 16'd2048;
            dot_reg         <= '0;
            max_reg         <= {1'b1, {(SCORE_W-1){1'b0}}};
            sum_reg         <= '0;
            recip_reg       <= '0;
            acc_valid_reg   <= '0;
            walk_addr_reg   <= '0;
            rcv_cnt_reg     <= '0;
            emit_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
            sc_rd_valid_reg <= 1'b0;
            div_start_reg   <= 1'b0;
        end
        else
        begin
            sc_rd_valid_reg <= s_re;
            div_start_reg   <= 1'b0;
            if (cfg_wr_en)
                scale_reg <= cfg_wr_data;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_DECODE;
                end
                S_DECODE:
                begin
                    priority if (kind_reg == KIND_QUERY)
                    begin
                        // Restart the row.
                        tokens_reg    <= count_clamped;
                        dot_reg       <= '0;
                        max_reg       <= {1'b1, {(SCORE_W-1){1'b0}}};
                        sum_reg       <= '0;
                        recip_reg     <= '0;
                        acc_valid_reg <= '0;
                        phase_reg     <= PH_KEYS;
                        state_reg     <= S_IDLE;
                    end
                    else if (q_re)
                    begin
                        state_reg <= S_K_MUL;
                    end
                    else if (kind_reg == KIND_VALUE && tok_ok && phase_reg == PH_KEYS)
                    begin
                        walk_addr_reg <= '0;
                        rcv_cnt_reg   <= '0;
                        sum_reg       <= '0;
                        state_reg     <= S_W_RUN;
                    end
                    else if (kind_reg == KIND_VALUE && tok_ok && phase_reg == PH_VALUES)
                    begin
                        state_reg <= S_V_RD;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_K_MUL:
                    state_reg <= S_K_ACC;
                S_K_ACC:
                begin
                    dot_reg   <= dot_new;
                    state_reg <= (chunk_reg == LAST_CHUNK) ? S_K_SCALE : S_IDLE;
                end
                S_K_SCALE:
                    state_reg <= S_K_SCORE;
                S_K_SCORE:
                begin
                    if (score_new > max_reg)
                        max_reg <= score_new;
                    dot_reg   <= '0;
                    state_reg <= S_IDLE;
                end
                S_W_RUN:
                begin
                    if (s_re)
                        walk_addr_reg <= walk_addr_reg + COUNT_W'(1);
                    if (exp_valid)
                    begin
                        sum_reg     <= sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
                        rcv_cnt_reg <= rcv_cnt_reg + COUNT_W'(1);
                    end
                    else if (rcv_cnt_reg == tokens_reg)
                    begin
                        if (sum_reg == '0)
                        begin
                            recip_reg <= '0;
                            phase_reg <= PH_VALUES;
                            state_reg <= S_V_RD;
                        end
                        else
                        begin
                            div_start_reg <= 1'b1;
                            state_reg     <= S_W_DIV;
                        end
                    end
                end
                S_W_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        recip_reg <= div_rsp.quotient;
                        phase_reg <= PH_VALUES;
                        state_reg <= S_V_RD;
                    end
                end
                S_V_RD:
                    state_reg <= S_V_EXP;
                S_V_EXP:
                begin
                    if (exp_valid)
                        state_reg <= S_V_MAC;
                end
                S_V_MAC:
                    state_reg <= S_V_WR;
                S_V_WR:
                begin
                    acc_valid_reg[chunk_reg] <= 1'b1;
                    if (tok_last && chunk_reg == LAST_CHUNK)
                    begin
                        emit_cnt_reg <= '0;
                        state_reg    <= S_E_RD;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_E_RD:
                    state_reg <= S_E_LOAD;
                S_E_LOAD:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_E_WAIT;
                end
                S_E_WAIT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (emit_cnt_reg == LAST_CHUNK)
                        begin
                            phase_reg <= PH_IDLE;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            emit_cnt_reg <= emit_cnt_reg + CHUNK_W'(1);
                            state_reg    <= S_E_RD;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Payload registers: hold the transaction and intermediate products
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            kind_reg   <= kind;
            tok_reg    <= token_index;
            chunk_reg  <= chunk_index;
            count_reg  <= token_count;
            val_reg[0] <= value_0;
            val_reg[1] <= value_1;
            val_reg[2] <= value_2;
            val_reg[3] <= value_3;
        end
        if (state_reg == S_K_MUL)
        begin
            for (int i = 0; i < LANES; i++)
                kprod_reg[i] <= q_lane[i] * val_reg[i];
        end
        if (state_reg == S_K_SCALE)
            sprod_reg <= dot_reg * $signed({1'b0, scale_reg});
        if (state_reg == S_V_EXP && exp_valid)
            p_reg <= pprod[49:32];
        if (state_reg == S_V_MAC)
        begin
            for (int i = 0; i < LANES; i++)
                vprod_reg[i] <= val_reg[i] * $signed({1'b0, p_reg});
        end
        if (state_reg == S_E_LOAD)
        begin
            for (int i = 0; i < LANES; i++)
                out_lane_reg[i] <= out_sat[i];
            out_chunk_reg <= emit_cnt_reg;
            out_last_reg  <= (emit_cnt_reg == LAST_CHUNK);
        end
    end

    // Accept a new transaction only while the sequencer is idle.
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_chunk = out_chunk_reg;
    assign out_0     = out_lane_reg[0];
    assign out_1     = out_lane_reg[1];
    assign out_2     = out_lane_reg[2];
    assign out_3     = out_lane_reg[3];
    assign out_last  = out_last_reg;

`ifndef SYNTHESIS
    a_emit_in_values: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> phase_reg == PH_VALUES)
        else $error("result shown outside the value phase");

    a_last_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_last |=> phase_reg == PH_IDLE && !out_valid)
        else $error("row not closed after the last result");

    a_recip_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_KEYS |-> recip_reg == '0)
        else $error("reciprocal set before the softmax walk");

    a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_W_RUN |-> rcv_cnt_reg <= tokens_reg && walk_addr_reg <= tokens_reg)
        else $error("softmax walk overran the token count");
`endif

endmodule

// ===== hw/rtl/sqad_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module sqad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/sqad_exp.sv =====
`timescale 1ns / 1ps
// Three-stage pipeline forming 2^((score - max) * log2 e) in Q1.16.
module sqad_exp
    import sqad_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic signed [SCORE_W-1:0] score,
    input  logic signed [SCORE_W-1:0] run_max,
    output logic                      out_valid,
    output logic [EXP_W-1:0]          e_out
);

    logic signed [SCORE_W:0] x;
    logic [20:0]             x_clip;
    logic                    big;
    logic [51:0]             prod_reg;
    logic                    big1_reg;
    logic [21:0]             y;
    logic [16:0]             idx_sum;
    logic [5:0]              k_reg;
    logic [EIDX_W-1:0]       idx_reg;
    logic                    big2_reg;
    logic [EXP_W:0]          rnd;
    logic [EXP_W:0]          t_sum;
    logic [EXP_W-1:0]        e_reg;
    logic [2:0]              vld_reg;

    // Stage 1: distance below the maximum, scaled by log2 e.
    always_comb
    begin
        x = (SCORE_W+1)'(run_max) - (SCORE_W+1)'(score);
        if (x < 0)
            x = '0;
        big    = x > (SCORE_W+1)'(17 << 16);
        x_clip = x[20:0];
    end

    // Stage 2: split into integer shift and table index, carry on rounding over.
    always_comb
    begin
        y       = 22'((prod_reg + (52'd1 << 29)) >> 30);
        idx_sum = {1'b0, y[15:0]} + 17'd128;
    end

    // Stage 3: table lookup and rounded shift.
    always_comb
    begin
        rnd   = (k_reg == 6'd0) ? '0 : (EXP_W+1)'(1) << (k_reg - 6'd1);
        t_sum = {1'b0, EXP_TABLE[idx_reg]} + rnd;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= {31'd0, x_clip} * 52'(LOG2E_Q30);
        big1_reg <= big;
        k_reg    <= y[21:16] + {5'd0, idx_sum[16]};
        idx_reg  <= idx_sum[15:8];
        big2_reg <= big1_reg;
        if (big2_reg || k_reg > 6'd16)
            e_reg <= '0;
        else
            e_reg <= EXP_W'(t_sum >> k_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[1:0], in_valid};
    end

    assign out_valid = vld_reg[2];
    assign e_out     = e_reg;

endmodule

// ===== hw/rtl/sqad_recip.sv =====
`timescale 1ns / 1ps
// Bit-serial restoring divider for round(2^48 / sum), saturated to 32 bits.
module sqad_recip
    import sqad_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int NUM_W = 49;

    logic             busy_reg;
    logic             done_reg;
    logic [5:0]       cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [31:0]      rem_reg;
    logic [31:0]      div_reg;
    logic [32:0]      rem_sh;
    logic             ge;
    logic [32:0]      rem_new;

    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[NUM_W-1]};
        ge      = rem_sh >= {1'b0, div_reg};
        rem_new = ge ? rem_sh - {1'b0, div_reg} : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(NUM_W);
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Quotient bits shift in at the bottom as numerator bits leave the top.
    always_ff @(posedge clk)
    begin
        if (req.start) begin
            num_reg <= (NUM_W'(1) << 48) + NUM_W'(req.divisor >> 1);
            rem_reg <= '0;
            div_reg <= req.divisor;
        end
        else if (busy_reg) begin
            num_reg <= {num_reg[NUM_W-2:0], ge};
            rem_reg <= rem_new[31:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = (|num_reg[NUM_W-1:32]) ? 32'hFFFF_FFFF : num_reg[31:0];

endmodule
